// ===== src/spq_pkg.sv =====
// shared types and constants of the sorted priority queue
package spq_pkg;

	// payload handle width, fixed by the word format
	localparam int PAYLOAD_W = 16;

	// opcode carried in s_tuser
	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_POP  = 1'b1;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_POP_EMPTY  = 2'd1,
		ST_PUSH_FULL  = 2'd2
	} status_t;

	// operation broadcast to every cell
	typedef struct packed {
		logic push;
		logic pop;
	} cmd_t;

	// per-cell status seen by the next cell down the chain
	typedef struct packed {
		logic occ;
		logic take;
	} link_t;

endpackage

// ===== src/spq_cell.sv =====
// one slot of the sorted chain: holds an entry and shifts with its neighbors
module spq_cell #(
	parameter int KEY_WIDTH = 16,
	parameter bit FIRST     = 1'b0
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  spq_pkg::cmd_t                  cmd,
	input  logic [KEY_WIDTH-1:0]           new_key,
	input  logic [spq_pkg::PAYLOAD_W-1:0]  new_payload,
	input  spq_pkg::link_t                 left_link,
	input  logic [KEY_WIDTH-1:0]           left_key,
	input  logic [spq_pkg::PAYLOAD_W-1:0]  left_payload,
	input  logic                           right_occ,
	input  logic [KEY_WIDTH-1:0]           right_key,
	input  logic [spq_pkg::PAYLOAD_W-1:0]  right_payload,
	output spq_pkg::link_t                 link,
	output logic [KEY_WIDTH-1:0]           key,
	output logic [spq_pkg::PAYLOAD_W-1:0]  payload
);

	logic                          occ_q;
	logic [KEY_WIDTH-1:0]          key_q;
	logic [spq_pkg::PAYLOAD_W-1:0] payload_q;
	logic                          take;
	logic                          load_new;

	// new entry goes ahead of this one; the head yields only on a strictly greater key
	always_comb begin
		if (FIRST) begin
			take = occ_q && ($signed(key_q) > $signed(new_key));
		end else begin
			take = occ_q && ($signed(key_q) >= $signed(new_key));
		end
		load_new = !left_link.take && (take || (!occ_q && left_link.occ));
	end

	// occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
		end else if (cmd.push) begin
			if (left_link.take || load_new) begin
				occ_q <= 1'b1;
			end
		end else if (cmd.pop) begin
			occ_q <= right_occ;
		end
	end

	// entry data: shift right on push behind the insert point, shift left on pop
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			if (left_link.take) begin
				key_q     <= left_key;
				payload_q <= left_payload;
			end else if (load_new) begin
				key_q     <= new_key;
				payload_q <= new_payload;
			end
		end else if (cmd.pop) begin
			key_q     <= right_key;
			payload_q <= right_payload;
		end
	end

	assign link.occ  = occ_q;
	assign link.take = take;
	assign key       = key_q;
	assign payload   = payload_q;

endmodule

// ===== src/sorted_priority_queue.sv =====
// sorted min-priority queue built as a chain of compare-and-shift cells
// result: the word for an accepted item is registered and valid in the cycle after acceptance
// throughput: one push or pop per cycle while no result word stalls; every cell compares
// against the broadcast key in parallel and shifts with its neighbor in the same cycle
// reset: arst_n empties the queue (all cells unoccupied, count zero) and drops m_tvalid
// entry data registers hold no reset value; unoccupied cells are never shown
module sorted_priority_queue #(
	parameter int DEPTH     = 16,
	parameter int KEY_WIDTH = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	// priority_req, payload
	input  logic [((KEY_WIDTH+spq_pkg::PAYLOAD_W+7)/8)*8-1:0] s_tdata,
	// opcode
	input  logic          s_tuser,
	output logic          m_tvalid,
	input  logic          m_tready,
	// head_priority, head_payload, is_empty, count, status
	output logic [((KEY_WIDTH+spq_pkg::PAYLOAD_W+$clog2(DEPTH+1)+3+7)/8)*8-1:0] m_tdata
);

	localparam int PW     = spq_pkg::PAYLOAD_W;
	localparam int CW     = $clog2(DEPTH + 1);
	localparam int OW_RAW = KEY_WIDTH + PW + 1 + CW + 2;

	logic [CW-1:0]          count_q;
	spq_pkg::status_t       status_q;
	logic                   m_tvalid_q;
	logic                   accept;
	logic                   full;
	logic                   empty;
	spq_pkg::cmd_t          cmd;
	logic [KEY_WIDTH-1:0]   in_key;
	logic [PW-1:0]          in_payload;

	spq_pkg::link_t         links    [DEPTH];
	logic [KEY_WIDTH-1:0]   keys     [DEPTH];
	logic [PW-1:0]          payloads [DEPTH];

	// handshake: a new word enters whenever the output register is free or being drained
	assign s_tready   = !m_tvalid_q || m_tready;
	assign accept     = s_tvalid && s_tready;
	assign full       = (count_q == CW'(DEPTH));
	assign empty      = (count_q == '0);
	assign in_key     = s_tdata[KEY_WIDTH-1:0];
	assign in_payload = s_tdata[KEY_WIDTH +: PW];

	// operation broadcast; rejected ops leave the chain untouched
	always_comb begin
		cmd.push = accept && (s_tuser == spq_pkg::OP_PUSH) && !full;
		cmd.pop  = accept && (s_tuser == spq_pkg::OP_POP) && !empty;
	end

	// cell chain
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		spq_pkg::link_t       l_link;
		logic [KEY_WIDTH-1:0] l_key;
		logic [PW-1:0]        l_payload;
		logic                 r_occ;
		logic [KEY_WIDTH-1:0] r_key;
		logic [PW-1:0]        r_payload;

		if (i == 0) begin : g_left_edge
			assign l_link.occ  = 1'b1;
			assign l_link.take = 1'b0;
			assign l_key       = '0;
			assign l_payload   = '0;
		end else begin : g_left
			assign l_link    = links[i-1];
			assign l_key     = keys[i-1];
			assign l_payload = payloads[i-1];
		end

		if (i == DEPTH - 1) begin : g_right_edge
			assign r_occ     = 1'b0;
			assign r_key     = '0;
			assign r_payload = '0;
		end else begin : g_right
			assign r_occ     = links[i+1].occ;
			assign r_key     = keys[i+1];
			assign r_payload = payloads[i+1];
		end

		spq_cell #(
			.KEY_WIDTH(KEY_WIDTH),
			.FIRST    (i == 0)
		) u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.cmd          (cmd),
			.new_key      (in_key),
			.new_payload  (in_payload),
			.left_link    (l_link),
			.left_key     (l_key),
			.left_payload (l_payload),
			.right_occ    (r_occ),
			.right_key    (r_key),
			.right_payload(r_payload),
			.link         (links[i]),
			.key          (keys[i]),
			.payload      (payloads[i])
		);
	end

	// entry count, result valid flag and status of the last accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			status_q   <= spq_pkg::ST_OK;
			m_tvalid_q <= 1'b0;
		end else begin
			if (accept) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (cmd.push) begin
				count_q <= count_q + 1'b1;
			end else if (cmd.pop) begin
				count_q <= count_q - 1'b1;
			end
			if (accept) begin
				if (s_tuser == spq_pkg::OP_POP) begin
					status_q <= empty ? spq_pkg::ST_POP_EMPTY : spq_pkg::ST_OK;
				end else begin
					status_q <= full ? spq_pkg::ST_PUSH_FULL : spq_pkg::ST_OK;
				end
			end
		end
	end

	// result word from the head cell; state holds while the word waits
	always_comb begin
		m_tdata = '0;
		m_tdata[OW_RAW-1:0] = {
			status_q,
			count_q,
			!links[0].occ,
			links[0].occ ? payloads[0] : {PW{1'b0}},
			links[0].occ ? keys[0] : {KEY_WIDTH{1'b0}}
		};
	end

	assign m_tvalid = m_tvalid_q;

endmodule

// ===== src/spq_checker.sv =====
// port-level checks of the sorted priority queue result stream
module spq_checker #(
	parameter int DEPTH     = 16,
	parameter int KEY_WIDTH = 16
) (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	input logic s_tready,
	input logic m_tvalid,
	input logic m_tready,
	input logic [((KEY_WIDTH+spq_pkg::PAYLOAD_W+$clog2(DEPTH+1)+3+7)/8)*8-1:0] m_tdata
);

	localparam int PW    = spq_pkg::PAYLOAD_W;
	localparam int CW    = $clog2(DEPTH + 1);
	localparam int E_POS = KEY_WIDTH + PW;
	localparam int C_POS = E_POS + 1;
	localparam int S_POS = C_POS + CW;

	logic [KEY_WIDTH-1:0] f_key;
	logic [PW-1:0]        f_payload;
	logic                 f_empty;
	logic [CW-1:0]        f_count;
	logic [1:0]           f_status;

	assign f_key     = m_tdata[KEY_WIDTH-1:0];
	assign f_payload = m_tdata[KEY_WIDTH +: PW];
	assign f_empty   = m_tdata[E_POS];
	assign f_count   = m_tdata[C_POS +: CW];
	assign f_status  = m_tdata[S_POS +: 2];

	// a stalled result word stays valid
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result word dropped while stalled");

	// each accepted word yields a result on the next cycle
	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> m_tvalid)
		else $error("accepted word produced no result");

	// count never exceeds the capacity and matches the empty flag
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (f_count <= CW'(DEPTH)) && (f_empty == (f_count == '0)))
		else $error("count inconsistent with capacity or empty flag");

	// an empty queue shows a zero head
	a_empty_head: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && f_empty |-> (f_key == '0) && (f_payload == '0))
		else $error("empty queue shows a nonzero head");

	// status codes agree with the occupancy they report
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (f_status != 2'd3)
			&& ((f_status != spq_pkg::ST_POP_EMPTY) || f_empty)
			&& ((f_status != spq_pkg::ST_PUSH_FULL) || (f_count == CW'(DEPTH))))
		else $error("status disagrees with queue occupancy");

endmodule

bind sorted_priority_queue spq_checker #(
	.DEPTH    (DEPTH),
	.KEY_WIDTH(KEY_WIDTH)
) u_spq_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);

// ===== dv/sorted_priority_queue_test.sv =====
// self-checking testbench for the sorted priority queue: shadow queue, stream drivers, checker
module sorted_priority_queue_test;

	localparam int DEPTH     = 16;
	localparam int KEY_W     = 16;
	localparam int PAYLOAD_W = spq_pkg::PAYLOAD_W;
	localparam int CNT_W     = $clog2(DEPTH + 1);
	localparam int S_W       = ((KEY_W + PAYLOAD_W + 7) / 8) * 8;
	localparam int M_W       = ((KEY_W + PAYLOAD_W + CNT_W + 3 + 7) / 8) * 8;

	// bit positions inside the result word
	localparam int POS_PAY   = KEY_W;
	localparam int POS_EMPTY = KEY_W + PAYLOAD_W;
	localparam int POS_CNT   = POS_EMPTY + 1;
	localparam int POS_ST    = POS_CNT + CNT_W;

	// hard stop, well past the slowest legal run
	localparam longint RUN_LIMIT = 64'd8_000_000;

	typedef struct {
		logic [KEY_W-1:0]     head_priority;
		logic [PAYLOAD_W-1:0] head_payload;
		logic                 is_empty;
		logic [CNT_W-1:0]     count;
		spq_pkg::status_t     status;
	} head_report_t;

	logic           clk;
	logic           arst_n;
	logic           s_tvalid;
	logic           s_tready;
	// priority_req, payload
	logic [S_W-1:0] s_tdata;
	// opcode
	logic           s_tuser;
	logic           m_tvalid;
	logic           m_tready;
	// head_priority, head_payload, is_empty, count, status
	logic [M_W-1:0] m_tdata;

	// shadow copy of the queue contents
	logic signed [KEY_W-1:0] shadow_keys [DEPTH];
	logic [PAYLOAD_W-1:0]    shadow_pays [DEPTH];
	int                      shadow_count;

	head_report_t pending_reports [$];
	int           error_count;
	bit           no_idle;
	int           hold_reqs;
	int           hold_done;
	int           hold_len;

	sorted_priority_queue #(
		.DEPTH(DEPTH),
		.KEY_WIDTH(KEY_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	// clock
	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// run limit
	initial begin
		#(RUN_LIMIT);
		$display("FAIL sorted_priority_queue");
		$finish;
	end

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		if ($urandom_range(0, 19) < 16)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// priorities biased toward extremes and tight clusters for ties
	function automatic logic [KEY_W-1:0] pick_priority();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return 16'h7fff;
		if (r == 1)
			return 16'h8000;
		if (r < 5)
			return KEY_W'($signed($urandom_range(0, 7)) - 4);
		return KEY_W'($urandom);
	endfunction

	// apply one word to the shadow queue and return the head report it causes
	function automatic head_report_t shadow_step(input logic op,
			input logic signed [KEY_W-1:0] prio, input logic [PAYLOAD_W-1:0] pay);
		head_report_t r;
		int pos;
		int i;
		r.status = spq_pkg::ST_OK;
		if (op == spq_pkg::OP_PUSH) begin
			if (shadow_count >= DEPTH) begin
				r.status = spq_pkg::ST_PUSH_FULL;
			end else begin
				// ahead of the head only if strictly smaller, else before first key >= prio
				if (shadow_count == 0 || shadow_keys[0] > prio) begin
					pos = 0;
				end else begin
					pos = 1;
					while (pos < shadow_count && shadow_keys[pos] < prio)
						pos++;
				end
				for (i = shadow_count; i > pos; i--) begin
					shadow_keys[i] = shadow_keys[i-1];
					shadow_pays[i] = shadow_pays[i-1];
				end
				shadow_keys[pos] = prio;
				shadow_pays[pos] = pay;
				shadow_count++;
			end
		end else begin
			if (shadow_count == 0) begin
				r.status = spq_pkg::ST_POP_EMPTY;
			end else begin
				for (i = 1; i < shadow_count; i++) begin
					shadow_keys[i-1] = shadow_keys[i];
					shadow_pays[i-1] = shadow_pays[i];
				end
				shadow_count--;
			end
		end
		if (shadow_count == 0) begin
			r.head_priority = '0;
			r.head_payload  = '0;
			r.is_empty      = 1'b1;
		end else begin
			r.head_priority = shadow_keys[0];
			r.head_payload  = shadow_pays[0];
			r.is_empty      = 1'b0;
		end
		r.count = CNT_W'(shadow_count);
		return r;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("mismatch at %0t: %s got %0d, expected %0d", $time, what, got, want);
		error_count++;
	endtask

	// offer one word, wait for acceptance, then log its expected report
	task automatic send_word(input logic op, input logic [KEY_W-1:0] prio,
			input logic [PAYLOAD_W-1:0] pay);
		int gap;
		gap = 0;
		if (!no_idle && $urandom_range(0, 3) == 0)
			gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= S_W'({pay, prio});
		do @(posedge clk); while (!s_tready);
		pending_reports.push_back(shadow_step(op, prio, pay));
	endtask

	task automatic push_word(input logic [KEY_W-1:0] prio, input logic [PAYLOAD_W-1:0] pay);
		send_word(spq_pkg::OP_PUSH, prio, pay);
	endtask

	// pop with random don't-care data
	task automatic pop_word();
		send_word(spq_pkg::OP_POP, KEY_W'($urandom), PAYLOAD_W'($urandom));
	endtask

	// sender pause until every report is back
	task automatic idle_until_drained();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending_reports.size() != 0);
	endtask

	// empty pop, extremes, ties with head, middle and tail
	task automatic test_directed();
		pop_word();
		push_word(16'h0000, 16'h0000);
		push_word(16'h8000, 16'hffff);
		push_word(16'h8000, 16'h1111);
		push_word(16'h7fff, 16'h2222);
		push_word(16'h0000, 16'h3333);
		push_word(16'h7fff, 16'h4444);
		push_word(16'h0001, 16'haaaa);
		repeat (8) pop_word();
		push_word(16'hffff, 16'h5555);
		push_word(16'hffff, 16'h6666);
		pop_word();
		pop_word();
		idle_until_drained();
	endtask

	// fill past capacity, then drain past empty
	task automatic test_full_queue();
		repeat (DEPTH + 3) push_word(pick_priority(), PAYLOAD_W'($urandom));
		repeat (DEPTH + 2) pop_word();
		idle_until_drained();
	endtask

	// receiver holds off while the sender keeps offering words without idling
	task automatic test_output_stall();
		no_idle   = 1'b1;
		hold_len  = 80;
		hold_reqs++;
		repeat (50) push_word(pick_priority(), PAYLOAD_W'($urandom));
		repeat (30) pop_word();
		no_idle = 1'b0;
		idle_until_drained();
	endtask

	// back-to-back words with no idling on either side
	task automatic test_back_to_back();
		no_idle = 1'b1;
		repeat (150) begin
			if ($urandom_range(0, 1) == 0)
				push_word(pick_priority(), PAYLOAD_W'($urandom));
			else
				pop_word();
		end
		no_idle = 1'b0;
	endtask

	// bursts that lean toward filling, churning or draining
	task automatic test_random_mix(input int total);
		int sent;
		int burst;
		int push_pct;
		sent = 0;
		while (sent < total) begin
			case ($urandom_range(0, 2))
				0: push_pct = 85;
				1: push_pct = 50;
				default: push_pct = 15;
			endcase
			burst = $urandom_range(20, 60);
			repeat (burst) begin
				if ($urandom_range(0, 99) < push_pct)
					push_word(pick_priority(), PAYLOAD_W'($urandom));
				else
					pop_word();
				sent++;
			end
		end
	endtask

	// compare each result word with the oldest expected report
	always @(posedge clk) begin
		head_report_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_reports.size() == 0) begin
				report_mismatch("pending reports", 0, 1);
			end else begin
				want = pending_reports.pop_front();
				if (m_tdata[KEY_W-1:0] !== want.head_priority)
					report_mismatch("head_priority", $signed(m_tdata[KEY_W-1:0]),
						$signed(want.head_priority));
				if (m_tdata[POS_PAY +: PAYLOAD_W] !== want.head_payload)
					report_mismatch("head_payload", m_tdata[POS_PAY +: PAYLOAD_W],
						want.head_payload);
				if (m_tdata[POS_EMPTY] !== want.is_empty)
					report_mismatch("is_empty", m_tdata[POS_EMPTY], want.is_empty);
				if (m_tdata[POS_CNT +: CNT_W] !== want.count)
					report_mismatch("count", m_tdata[POS_CNT +: CNT_W], want.count);
				if (m_tdata[POS_ST +: 2] !== want.status)
					report_mismatch("status", m_tdata[POS_ST +: 2], want.status);
			end
		end
	end

	// receiver: random stalls, requested long hold-offs, or steady ready
	initial begin
		m_tready <= 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (hold_done != hold_reqs) begin
				m_tready <= 1'b0;
				repeat (hold_len) @(posedge clk);
				hold_done++;
			end else if (!no_idle && $urandom_range(0, 3) == 0) begin
				m_tready <= 1'b0;
				repeat (pick_gap()) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
		end
	end

	// reset, test sequence, final verdict
	initial begin
		error_count  = 0;
		shadow_count = 0;
		no_idle      = 1'b0;
		hold_reqs    = 0;
		hold_done    = 0;
		hold_len     = 1;
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tuser  <= spq_pkg::OP_PUSH;
		s_tdata  <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_full_queue();
		test_output_stall();
		test_back_to_back();
		test_random_mix(1000);

		s_tvalid <= 1'b0;
		while (pending_reports.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (error_count == 0 && pending_reports.size() == 0)
			$display("PASS sorted_priority_queue");
		else
			$display("FAIL sorted_priority_queue");
		$finish;
	end

endmodule

// ===== files.f =====
src/spq_pkg.sv
src/spq_cell.sv
src/sorted_priority_queue.sv
src/spq_checker.sv
dv/sorted_priority_queue_test.sv
